### rtl/phca_pkg.sv
package phca_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 2;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int RAD_W = 2 * COORD_W + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int ITER_W = $clog2(CORDIC_ITERATIONS + 1);
	localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
	localparam int CNT_W = (ITER_W > ROOT_CNT_W) ? ITER_W : ROOT_CNT_W;
	localparam int ATAN_IDX_W = 5;
	localparam int NORM_TOP = 57;
	localparam int CV_W = NORM_TOP + 4;
	localparam int ANG_W = 34;
	localparam int HEAD_W = 16;
	localparam int HEAD_SHIFT = 16;
	localparam int CURV_W = 63;
	localparam int LEN_W = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(1 << 30);
	localparam logic signed [ANG_W-1:0] ANG_ROUND = ANG_W'(32768);

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x_in;
		logic signed [COORD_W-1:0] point_y_in;
		logic path_end;
	} pt_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x_out;
		logic signed [COORD_W-1:0] point_y_out;
		logic signed [HEAD_W-1:0] heading;
		logic [CURV_W-1:0] curvature_term;
		logic [LEN_W-1:0] arc_length;
		logic too_short;
		logic last_result;
	} res_t;

	typedef enum logic [1:0] {
		SEG_NONE,
		SEG_SET,
		SEG_ADD
	} seg_op_t;

	typedef struct packed {
		logic emit;
		logic too_short;
		logic last;
		logic arc_zero;
		seg_op_t seg_op;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [DIFF_W-1:0] d1x;
		logic signed [DIFF_W-1:0] d1y;
		logic signed [DIFF_W-1:0] d2x;
		logic signed [DIFF_W-1:0] d2y;
		logic signed [DIFF_W-1:0] sdx;
		logic signed [DIFF_W-1:0] sdy;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SQX,
		B_SQY,
		B_SQS,
		B_SQRT,
		B_LEN,
		B_CP,
		B_CQ,
		B_CS,
		B_NORM,
		B_ROT,
		B_OUT
	} back_st_t;

	function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_W-1:0] v);
		sx = {{(DIFF_W - COORD_W){v[COORD_W-1]}}, v};
	endfunction

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_unit(input logic [ATAN_IDX_W-1:0] i);
		case (i)
			5'd0: atan_unit = 32'd536870912;
			5'd1: atan_unit = 32'd316933406;
			5'd2: atan_unit = 32'd167458907;
			5'd3: atan_unit = 32'd85004756;
			5'd4: atan_unit = 32'd42667331;
			5'd5: atan_unit = 32'd21354465;
			5'd6: atan_unit = 32'd10679838;
			5'd7: atan_unit = 32'd5340245;
			5'd8: atan_unit = 32'd2670163;
			5'd9: atan_unit = 32'd1335087;
			5'd10: atan_unit = 32'd667544;
			5'd11: atan_unit = 32'd333772;
			5'd12: atan_unit = 32'd166886;
			5'd13: atan_unit = 32'd83443;
			5'd14: atan_unit = 32'd41722;
			5'd15: atan_unit = 32'd20861;
			5'd16: atan_unit = 32'd10430;
			5'd17: atan_unit = 32'd5215;
			5'd18: atan_unit = 32'd2608;
			5'd19: atan_unit = 32'd1304;
			5'd20: atan_unit = 32'd652;
			5'd21: atan_unit = 32'd326;
			5'd22: atan_unit = 32'd163;
			5'd23: atan_unit = 32'd81;
			5'd24: atan_unit = 32'd41;
			5'd25: atan_unit = 32'd20;
			5'd26: atan_unit = 32'd10;
			5'd27: atan_unit = 32'd5;
			5'd28: atan_unit = 32'd3;
			5'd29: atan_unit = 32'd1;
			5'd30: atan_unit = 32'd1;
			default: atan_unit = 32'd0;
		endcase
	endfunction

endpackage

### rtl/path_heading_curvature_arclength_top.sv
// Channel  | Signals                              | Moves
// ---------+--------------------------------------+-------------------------------
// point    | point_valid, point_stall, point      | one waypoint request in
// result   | result_valid, result_stall, result   | one point result request out
//
// Front takes a waypoint and then queues zero to three jobs, one a cycle while the queue
// is not full; point_stall is high until all are queued (queue holds four jobs).
// Back runs one job at a time: a segment job squares the differences, takes a 33-step
// root and adds to the running length; a result job pops, forms the cross product,
// normalizes and, unless the direction is zero, runs CORDIC_ITERATIONS rotation steps,
// then outputs its result.
// Reset clears the window, point count, running length, queue and result valid.
// A stalled result holds in the output register; the back waits, the front keeps
// queueing until the queue fills.
module path_heading_curvature_arclength_top import phca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_stall,
	input pt_in_t point,
	output logic result_valid,
	input logic result_stall,
	output res_t result
);

	logic push, pop;
	job_t push_job, pop_job;
	q_stat_t q_stat;

	// window, point count and job planning
	phca_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.push(push),
		.push_job(push_job),
		.q_stat(q_stat)
	);

	phca_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.pop_job(pop_job),
		.q_stat(q_stat)
	);

	// shared multiplier, root, CORDIC, running length, output register
	phca_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.pop(pop),
		.pop_job(pop_job),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

### rtl/phca_queue.sv
module phca_queue import phca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	input logic pop,
	output job_t pop_job,
	output q_stat_t q_stat
);

	job_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0] cnt_q;

	assign pop_job = mem_q[rd_q];
	assign q_stat.full = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/phca_front.sv
module phca_front import phca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_stall,
	input pt_in_t point,
	output logic push,
	output job_t push_job,
	input q_stat_t q_stat
);

	localparam int P_SHORT = 0;
	localparam int P_SET = 1;
	localparam int P_A = 2;
	localparam int P_B = 3;
	localparam int P_SEG = 4;
	localparam int P_C = 5;
	localparam int P_W = 6;

	logic [1:0] ps_q;
	logic signed [COORD_W-1:0] wox_q, woy_q, wnx_q, wny_q;
	logic signed [COORD_W-1:0] lox_q, loy_q, lnx_q, lny_q, lcx_q, lcy_q;
	logic [P_W-1:0] pend_q, pend_nx, sel;
	logic accept;
	logic signed [DIFF_W-1:0] d2x, d2y, dcnx, dcny, dnox, dnoy, dcox, dcoy;

	assign point_stall = |pend_q;
	assign accept = point_valid && !point_stall;
	assign sel = pend_q & (~pend_q + 1'b1);
	assign push = (|pend_q) && !q_stat.full;

	always_comb begin
		pend_nx = '0;
		case (ps_q)
			2'd0, 2'd1: begin
				if (point.path_end) begin
					pend_nx[P_SHORT] = 1'b1;
				end else if (ps_q == 2'd1) begin
					pend_nx[P_SET] = 1'b1;
				end
			end
			2'd2: begin
				pend_nx[P_A] = 1'b1;
				pend_nx[P_B] = !point.path_end;
				pend_nx[P_SEG] = !point.path_end;
				pend_nx[P_C] = point.path_end;
			end
			default: begin
				pend_nx[P_B] = 1'b1;
				pend_nx[P_SEG] = !point.path_end;
				pend_nx[P_C] = point.path_end;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lox_q <= wox_q;
			loy_q <= woy_q;
			lnx_q <= wnx_q;
			lny_q <= wny_q;
			lcx_q <= point.point_x_in;
			lcy_q <= point.point_y_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= '0;
			wox_q <= '0;
			woy_q <= '0;
			wnx_q <= '0;
			wny_q <= '0;
			pend_q <= '0;
		end else if (accept) begin
			pend_q <= pend_nx;
			if (point.path_end) begin
				ps_q <= '0;
				wox_q <= '0;
				woy_q <= '0;
				wnx_q <= '0;
				wny_q <= '0;
			end else begin
				wox_q <= wnx_q;
				woy_q <= wny_q;
				wnx_q <= point.point_x_in;
				wny_q <= point.point_y_in;
				if (ps_q != 2'd3) begin
					ps_q <= ps_q + 2'd1;
				end
			end
		end else if (push) begin
			pend_q <= pend_q & ~sel;
		end
	end

	assign d2x = sx(lcx_q) - (sx(lnx_q) <<< 1) + sx(lox_q);
	assign d2y = sx(lcy_q) - (sx(lny_q) <<< 1) + sx(loy_q);
	assign dcnx = sx(lcx_q) - sx(lnx_q);
	assign dcny = sx(lcy_q) - sx(lny_q);
	assign dnox = sx(lnx_q) - sx(lox_q);
	assign dnoy = sx(lny_q) - sx(loy_q);
	assign dcox = sx(lcx_q) - sx(lox_q);
	assign dcoy = sx(lcy_q) - sx(loy_q);

	always_comb begin
		push_job = '0;
		push_job.seg_op = SEG_NONE;
		push_job.d2x = d2x;
		push_job.d2y = d2y;
		push_job.sdx = dcnx;
		push_job.sdy = dcny;
		if (sel[P_SHORT]) begin
			push_job = '0;
			push_job.emit = 1'b1;
			push_job.too_short = 1'b1;
			push_job.last = 1'b1;
			push_job.seg_op = SEG_NONE;
		end else if (sel[P_SET]) begin
			push_job.seg_op = SEG_SET;
		end else if (sel[P_A]) begin
			push_job.emit = 1'b1;
			push_job.arc_zero = 1'b1;
			push_job.px = lox_q;
			push_job.py = loy_q;
			push_job.d1x = dnox <<< 1;
			push_job.d1y = dnoy <<< 1;
		end else if (sel[P_B]) begin
			push_job.emit = 1'b1;
			push_job.px = lnx_q;
			push_job.py = lny_q;
			push_job.d1x = dcox;
			push_job.d1y = dcoy;
		end else if (sel[P_SEG]) begin
			push_job.seg_op = SEG_ADD;
		end else begin
			push_job.emit = 1'b1;
			push_job.last = 1'b1;
			push_job.seg_op = SEG_ADD;
			push_job.px = lcx_q;
			push_job.py = lcy_q;
			push_job.d1x = dcnx <<< 1;
			push_job.d1y = dcny <<< 1;
		end
	end

endmodule

### rtl/phca_back.sv
module phca_back import phca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input q_stat_t q_stat,
	output logic pop,
	input job_t pop_job,
	output logic result_valid,
	input logic result_stall,
	output res_t result
);

	back_st_t st_q, st_nx;
	job_t ent_q;
	logic signed [DIFF_W-1:0] ma, mb;
	logic signed [PROD_W-1:0] mp, prod_q, acc_q;
	logic signed [CROSS_W-1:0] cross_q;
	logic [CROSS_W-1:0] cabs;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0] rem_sh, trial;
	logic root_ge;
	logic [LEN_W:0] len_sum;
	logic [LEN_W-1:0] rl_q;
	logic signed [CV_W-1:0] cx_q, cy_q, ax, ay, xs, ys;
	logic [CV_W-1:0] mor;
	logic signed [ANG_W-1:0] z_q, zr, at_s;
	logic [CNT_W-1:0] cnt_q;
	logic d1_zero, load;
	res_t out_q, res_nx;

	assign mp = ma * mb;
	assign d1_zero = (ent_q.d1x == '0) && (ent_q.d1y == '0);

	// one restoring square-root digit
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = (REM_W + 2)'({root_q, 2'b01});
	assign root_ge = rem_sh >= trial;
	assign len_sum = {1'b0, rl_q} + (LEN_W + 1)'(root_q);

	assign ax = cx_q[CV_W-1] ? -cx_q : cx_q;
	assign ay = cy_q[CV_W-1] ? -cy_q : cy_q;
	assign mor = ax | ay;
	assign xs = cx_q >>> cnt_q;
	assign ys = cy_q >>> cnt_q;
	assign at_s = ANG_W'(atan_unit(cnt_q[ATAN_IDX_W-1:0]));
	assign zr = z_q + ANG_ROUND;
	assign cabs = cross_q[CROSS_W-1] ? -cross_q : cross_q;

	always_comb begin
		st_nx = st_q;
		case (st_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					if (pop_job.too_short) begin
						st_nx = B_OUT;
					end else if (pop_job.seg_op != SEG_NONE) begin
						st_nx = B_SQX;
					end else begin
						st_nx = B_CP;
					end
				end
			end
			B_SQX: st_nx = B_SQY;
			B_SQY: st_nx = B_SQS;
			B_SQS: st_nx = B_SQRT;
			B_SQRT: begin
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					st_nx = B_LEN;
				end
			end
			B_LEN: st_nx = ent_q.emit ? B_CP : B_IDLE;
			B_CP: st_nx = B_CQ;
			B_CQ: st_nx = B_CS;
			B_CS: st_nx = d1_zero ? B_OUT : B_NORM;
			B_NORM: begin
				if (mor[NORM_TOP]) begin
					st_nx = B_ROT;
				end
			end
			B_ROT: begin
				if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
					st_nx = B_OUT;
				end
			end
			B_OUT: begin
				if (load) begin
					st_nx = B_IDLE;
				end
			end
			default: st_nx = B_IDLE;
		endcase
	end

	always_comb begin
		pop = (st_q == B_IDLE) && !q_stat.empty;
		load = (st_q == B_OUT) && (!result_valid || !result_stall);
		case (st_q)
			B_SQX: begin
				ma = ent_q.sdx;
				mb = ent_q.sdx;
			end
			B_SQY: begin
				ma = ent_q.sdy;
				mb = ent_q.sdy;
			end
			B_CP: begin
				ma = ent_q.d2y;
				mb = ent_q.d1x;
			end
			B_CQ: begin
				ma = ent_q.d2x;
				mb = ent_q.d1y;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		res_nx = '0;
		res_nx.too_short = ent_q.too_short;
		res_nx.last_result = ent_q.last;
		if (!ent_q.too_short) begin
			res_nx.point_x_out = ent_q.px;
			res_nx.point_y_out = ent_q.py;
			res_nx.heading = zr[HEAD_SHIFT +: HEAD_W];
			res_nx.curvature_term = (|cabs[CROSS_W-1:CURV_W]) ? '1 : cabs[CURV_W-1:0];
			res_nx.arc_length = ent_q.arc_zero ? '0 : rl_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= pop_job;
		end
		case (st_q)
			B_SQX: prod_q <= mp;
			B_SQY: begin
				acc_q <= prod_q;
				prod_q <= mp;
			end
			B_SQS: begin
				rad_q <= acc_q[RAD_W-1:0] + prod_q[RAD_W-1:0];
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
			end
			B_SQRT: begin
				rem_q <= root_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
				root_q <= {root_q[ROOT_W-2:0], root_ge};
				rad_q <= rad_q << 2;
				cnt_q <= cnt_q + 1'b1;
			end
			B_CP: prod_q <= mp;
			B_CQ: begin
				acc_q <= prod_q;
				prod_q <= mp;
			end
			B_CS: begin
				cross_q <= {acc_q[PROD_W-1], acc_q} - {prod_q[PROD_W-1], prod_q};
				cx_q <= {{(CV_W - DIFF_W){ent_q.d1x[DIFF_W-1]}}, ent_q.d1x};
				cy_q <= {{(CV_W - DIFF_W){ent_q.d1y[DIFF_W-1]}}, ent_q.d1y};
				z_q <= '0;
			end
			B_NORM: begin
				if (mor[NORM_TOP -: 8] == '0) begin
					cx_q <= cx_q <<< 8;
					cy_q <= cy_q <<< 8;
				end else if (!mor[NORM_TOP]) begin
					cx_q <= cx_q <<< 1;
					cy_q <= cy_q <<< 1;
				end else if (cx_q[CV_W-1]) begin
					// left half plane: quarter turn onto the right half first
					if (!cy_q[CV_W-1]) begin
						cx_q <= cy_q;
						cy_q <= -cx_q;
						z_q <= ANG_QUARTER;
					end else begin
						cx_q <= -cy_q;
						cy_q <= cx_q;
						z_q <= -ANG_QUARTER;
					end
				end
				cnt_q <= '0;
			end
			B_ROT: begin
				if (!cy_q[CV_W-1] && (cy_q != '0)) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q <= z_q + at_s;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q <= z_q - at_s;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (load) begin
			out_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			rl_q <= '0;
			result_valid <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (st_q == B_LEN) begin
				if (ent_q.seg_op == SEG_SET) begin
					rl_q <= LEN_W'(root_q);
				end else begin
					rl_q <= len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
				end
			end
			if (load) begin
				result_valid <= 1'b1;
				if (ent_q.last) begin
					rl_q <= '0;
				end
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	assign result = out_q;

endmodule

### rtl/phca_checker.sv
module phca_props import phca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	input logic point_stall,
	input pt_in_t point,
	input logic result_valid,
	input logic result_stall,
	input res_t result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.too_short |-> result.last_result)
		else $error("short path result not last");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.too_short |-> result.heading == 0 &&
		result.curvature_term == 0 && result.arc_length == 0 &&
		result.point_x_out == 0 && result.point_y_out == 0)
		else $error("short path result not cleared");

endmodule

bind path_heading_curvature_arclength_top phca_props u_chk (.*);

### tb/sv/phca_checker.sv
module phca_checker import phca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	input logic point_stall,
	input pt_in_t point,
	input logic result_valid,
	input logic result_stall,
	input res_t result,
	output int fails,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// atan(2^-i), 2^32 per turn
	localparam longint ATAN_TURN[32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0};
	localparam longint unsigned ARC_SAT = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned CURV_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

	res_t want_q[$];
	longint win_x0, win_y0, win_x1, win_y1;
	int seen;
	longint unsigned run_len;

	assign pending = want_q.size();

	function automatic longint unsigned mag64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned int_root(logic [127:0] n);
		longint unsigned r, c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	function automatic longint unsigned seg_length(longint x0, longint y0, longint x1,
		longint y1);
		logic [127:0] dx, dy;
		dx = mag64(x1 - x0);
		dy = mag64(y1 - y0);
		return int_root(dx * dx + dy * dy);
	endfunction

	function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return s > ARC_SAT ? ARC_SAT : s;
	endfunction

	function automatic longint unsigned cross_mag(longint d1x, longint d1y, longint d2x,
		longint d2y);
		logic signed [127:0] p, q, r;
		p = 128'(d2y) * 128'(d1x);
		q = 128'(d2x) * 128'(d1y);
		r = p - q;
		if (r < 0)
			r = -r;
		return (r > 128'(CURV_SAT)) ? CURV_SAT : 64'(r);
	endfunction

	function automatic logic [15:0] bearing(longint dx, longint dy);
		longint unsigned mx, my, m;
		longint x, y, z, t, xs, ys;
		mx = mag64(dx);
		my = mag64(dy);
		z = 0;
		if (mx == 0 && my == 0)
			return 16'd0;
		m = mx > my ? mx : my;
		// scale into [2^57, 2^58)
		while (m < (64'd1 << 57)) begin
			m <<= 1; mx <<= 1; my <<= 1;
		end
		while (m >= (64'd1 << 58)) begin
			m >>= 1; mx >>= 1; my >>= 1;
		end
		x = dx < 0 ? -longint'(mx) : longint'(mx);
		y = dy < 0 ? -longint'(my) : longint'(my);
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 64'sd1 << 30;
			end else begin
				x = -y; y = t; z = -(64'sd1 << 30);
			end
		end
		for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_TURN[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TURN[i];
			end
		end
		return 16'((z + 32768) >>> 16);
	endfunction

	function automatic res_t point_result(longint px, longint py, longint d1x, longint d1y,
		longint d2x, longint d2y, longint unsigned arc, logic last);
		res_t r;
		r.point_x_out = px[31:0];
		r.point_y_out = py[31:0];
		r.heading = bearing(d1x, d1y);
		r.curvature_term = cross_mag(d1x, d1y, d2x, d2y);
		r.arc_length = arc[47:0];
		r.too_short = 1'b0;
		r.last_result = last;
		return r;
	endfunction

	task automatic clear_path();
		win_x0 = 0; win_y0 = 0; win_x1 = 0; win_y1 = 0;
		seen = 0;
		run_len = 0;
	endtask

	task automatic take_point(pt_in_t p);
		longint x, y, d2x, d2y;
		res_t r;
		x = longint'(p.point_x_in);
		y = longint'(p.point_y_in);
		d2x = x - 2 * win_x1 + win_x0;
		d2y = y - 2 * win_y1 + win_y0;
		if (seen < 2) begin
			if (p.path_end) begin
				r = '0;
				r.too_short = 1'b1;
				r.last_result = 1'b1;
				want_q.push_back(r);
				clear_path();
				return;
			end
			run_len = (seen == 1) ? sat_add(0, seg_length(win_x1, win_y1, x, y)) : 0;
			win_x0 = win_x1; win_y0 = win_y1;
			win_x1 = x; win_y1 = y;
			seen++;
			return;
		end
		if (seen == 2)
			want_q.push_back(point_result(win_x0, win_y0, 2 * (win_x1 - win_x0),
				2 * (win_y1 - win_y0), d2x, d2y, 0, 1'b0));
		// three-point path drops the middle result
		if (!(seen == 2 && p.path_end))
			want_q.push_back(point_result(win_x1, win_y1, x - win_x0, y - win_y0,
				d2x, d2y, run_len, 1'b0));
		run_len = sat_add(run_len, seg_length(win_x1, win_y1, x, y));
		if (p.path_end) begin
			want_q.push_back(point_result(x, y, 2 * (x - win_x1), 2 * (y - win_y1),
				d2x, d2y, run_len, 1'b1));
			clear_path();
			return;
		end
		win_x0 = win_x1; win_y0 = win_y1;
		win_x1 = x; win_y1 = y;
		seen = 3;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fails++;
	endtask

	initial begin
		fails = 0;
		clear_path();
	end

	always @(posedge clk or negedge arst_n) begin
		res_t w;
		if (!arst_n) begin
			clear_path();
			want_q.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (want_q.size() == 0) begin
					report("unexpected result", 64'(result.arc_length), 64'd0);
				end else begin
					w = want_q.pop_front();
					if (result.point_x_out !== w.point_x_out)
						report("point_x_out", 64'(result.point_x_out),
							64'(w.point_x_out));
					if (result.point_y_out !== w.point_y_out)
						report("point_y_out", 64'(result.point_y_out),
							64'(w.point_y_out));
					if (result.heading !== w.heading)
						report("heading", 64'(result.heading), 64'(w.heading));
					if (result.curvature_term !== w.curvature_term)
						report("curvature_term", 64'(result.curvature_term),
							64'(w.curvature_term));
					if (result.arc_length !== w.arc_length)
						report("arc_length", 64'(result.arc_length), 64'(w.arc_length));
					if (result.too_short !== w.too_short)
						report("too_short", 64'(result.too_short), 64'(w.too_short));
					if (result.last_result !== w.last_result)
						report("last_result", 64'(result.last_result),
							64'(w.last_result));
				end
			end
			if (point_valid && !point_stall)
				take_point(point);
		end
	end
endmodule

### tb/sv/tb_path_heading_curvature_arclength_top.sv
module tb_path_heading_curvature_arclength_top;
	import phca_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	pt_in_t point = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	res_t result;
	int fails;
	int pending;

	// idle flavor: when low, the side runs flat out
	logic send_gaps = 1'b1;
	logic recv_gaps = 1'b1;
	int recv_hold = 0;
	int sent = 0;

	always #5 clk = ~clk;

	path_heading_curvature_arclength_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	phca_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.fails(fails),
		.pending(pending)
	);

	// result side: stall for a drawn count of cycles after each accepted request
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			result_stall <= 1'b1;
			recv_hold <= recv_hold - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			recv_hold <= recv_gaps ? $urandom_range(0, 19) : 0;
			// flip flavor now and then so some bursts run unstalled
			if ($urandom_range(0, 40) == 0)
				recv_gaps <= ~recv_gaps;
		end
	end

	// one waypoint request: gap, then hold valid until accepted
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
		int gap;
		gap = send_gaps ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		repeat (gap) @(negedge clk);
		point_valid <= 1'b1;
		point.point_x_in <= x;
		point.point_y_in <= y;
		point.path_end <= last;
		forever begin
			@(posedge clk);
			if (!point_stall)
				break;
		end
		sent++;
		@(negedge clk);
		point_valid <= 1'b0;
	endtask

	// hold off until the block has handed back everything owed
	task automatic drain();
		@(negedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// random path: full-range points, extremes, repeats and axis moves, or a short walk from a base
	task automatic random_path();
		int len, mode;
		logic [31:0] x, y;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
		mode = $urandom_range(0, 5);
		x = $urandom;
		y = $urandom;
		for (int i = 0; i < len; i++) begin
			if (mode == 0) begin
				x = $urandom;
				y = $urandom;
			end else if (mode == 1) begin
				x = pick_coord();
				y = pick_coord();
			end else if (mode == 2) begin
				// repeats and pure axis moves
				if ($urandom_range(0, 1))
					x = x + ($urandom_range(0, 2) - 1) * 32'h0001_0000;
				else
					y = y + ($urandom_range(0, 2) - 1) * 32'h0001_0000;
			end else begin
				x = x + 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
				y = y + 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
			end
			send_point(x, y, i == len - 1);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// too short: one point, then two points
		send_point(32'h0001_0000, 32'h0002_0000, 1'b1);
		send_point(32'h0, 32'h0, 1'b0);
		send_point(32'h0003_0000, 32'h0004_0000, 1'b1);
		// three points: middle result omitted
		send_point(32'h0, 32'h0, 1'b0);
		send_point(32'h0001_0000, 32'h0001_0000, 1'b0);
		send_point(32'h0002_0000, 32'h0, 1'b1);
		// four points, straight line
		send_point(32'h0, 32'h0, 1'b0);
		send_point(32'h0001_0000, 32'h0, 1'b0);
		send_point(32'h0002_0000, 32'h0, 1'b0);
		send_point(32'h0003_0000, 32'h0, 1'b1);
		// repeated point: zero difference
		send_point(32'h0005_0000, 32'hFFFB_0000, 1'b0);
		send_point(32'h0005_0000, 32'hFFFB_0000, 1'b0);
		send_point(32'h0005_0000, 32'hFFFB_0000, 1'b1);
		// heading of pi: moving toward -x
		send_point(32'h0002_0000, 32'h0001_0000, 1'b0);
		send_point(32'h0001_0000, 32'h0001_0000, 1'b0);
		send_point(32'h0, 32'h0001_0000, 1'b1);
		// coordinate extremes: saturating curvature and long segments
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		drain();

		while (sent < 1420) begin
			if ($urandom_range(0, 15) == 0)
				send_gaps = ~send_gaps;
			if ($urandom_range(0, 60) == 0)
				drain();
			random_path();
		end

		drain();
		repeat (300) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule

### path_heading_curvature_arclength_top.f
rtl/phca_pkg.sv
rtl/phca_queue.sv
rtl/phca_front.sv
rtl/phca_back.sv
rtl/path_heading_curvature_arclength_top.sv
rtl/phca_checker.sv
tb/sv/phca_checker.sv
tb/sv/tb_path_heading_curvature_arclength_top.sv
